[hw/rtl/segment_intersection_test_defines.svh]
// Assertion macros shared by the segment intersection checker.
`ifndef SEGMENT_INTERSECTION_TEST_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("segment intersection check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> (cons)) \
		else $error("segment intersection check failed");

`endif

[hw/rtl/sit_pkg.sv]
// Shared types and constants of the segment intersection test.
package sit_pkg;

	localparam int COORD_WIDTH_DEF = 16;

	typedef enum logic [2:0] {
		V_CROSSING   = 3'd0,
		V_DEGENERATE = 3'd1,
		V_SHARED     = 3'd2,
		V_SAME_SIDE  = 3'd3,
		V_OUTSIDE    = 3'd4,
		V_COLLINEAR  = 3'd5
	} verdict_t;

	// Load enables for the cross product stages.
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
	} sit_adv_t;

endpackage

[hw/rtl/sit_if.sv]
// Channel interfaces: segment endpoints in, verdict out.
interface sit_pt_if #(parameter int W = sit_pkg::COORD_WIDTH_DEF);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] ax;
	logic signed [W-1:0] ay;
	logic signed [W-1:0] bx;
	logic signed [W-1:0] by;
	logic signed [W-1:0] cx;
	logic signed [W-1:0] cy;
	logic signed [W-1:0] dx;
	logic signed [W-1:0] dy;

	modport source (output valid, ax, ay, bx, by, cx, cy, dx, dy, input ready);
	modport sink (input valid, ax, ay, bx, by, cx, cy, dx, dy, output ready);
endinterface

interface sit_res_if;
	logic       valid;
	logic       ready;
	logic       hit;
	logic [2:0] verdict;

	modport source (output valid, hit, verdict, input ready);
	modport sink (input valid, hit, verdict, output ready);
endinterface

[hw/rtl/sit_cross.sv]
// Two-stage pipelined 2D cross product a*d - b*c.
module sit_cross #(
	parameter int W = sit_pkg::COORD_WIDTH_DEF
) (
	input  logic                  clk,
	input  sit_pkg::sit_adv_t     adv,
	input  logic signed [W:0]     a,
	input  logic signed [W:0]     b,
	input  logic signed [W:0]     c,
	input  logic signed [W:0]     d,
	output logic signed [2*W+2:0] res_s3
);

	logic signed [2*W+1:0] ad_s2;
	logic signed [2*W+1:0] bc_s2;

	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			ad_s2 <= (2*W+2)'(a) * (2*W+2)'(d);
			bc_s2 <= (2*W+2)'(b) * (2*W+2)'(c);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s3) begin
			res_s3 <= (2*W+3)'(ad_s2) - (2*W+3)'(bc_s2);
		end
	end

endmodule

[hw/rtl/segment_intersection_test.sv]
// Top level: four-stage pipelined segment intersection test.
//
// segs carries one word per segment pair: endpoints A, B, C, D as signed
// COORD_WIDTH-bit fixed-point coordinates. result returns one word per
// input word, in order: hit and a 3-bit verdict (crossing, degenerate,
// shared endpoint, same side, outside AB, collinear).
// A result word turns valid once its input word has passed stages 1 to 4
// and is taken at a rising edge where the receiver holds ready high. While
// the receiver keeps ready high a new word enters every cycle; throughput is
// one pair per clock, set by the four parallel cross product units (one
// multiply stage and one subtract stage each).
// Each stage holds a valid bit; a stage loads whenever it is empty or the
// stage after it moves, so bubbles close up while the receiver stalls and
// segs.ready drops only once all four stages are full. A stalled result
// holds its value until taken.
// Reset clears all valid bits; no results are pending afterward.
// The interfaces bound to segs must be built with W equal to COORD_WIDTH.
module segment_intersection_test #(
	parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	sit_pt_if.sink        segs,
	sit_res_if.source     result
);

	localparam int W = COORD_WIDTH;

	// Valid bits and per-stage load enables
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	sit_pkg::sit_adv_t adv;

	assign rdy4 = !v_s4 || result.ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign segs.ready = rdy1;
	assign adv.ld_s2 = rdy2;
	assign adv.ld_s3 = rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= segs.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Stage 1: difference vectors and early-out flags
	logic signed [W:0] ux_s1, uy_s1;   // B - A
	logic signed [W:0] vcx_s1, vcy_s1; // C - A
	logic signed [W:0] vdx_s1, vdy_s1; // D - A
	logic signed [W:0] ex_s1, ey_s1;   // D - C
	logic signed [W:0] wx_s1, wy_s1;   // B - C
	logic degen_s1, shared_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			ux_s1  <= (W+1)'(segs.bx) - (W+1)'(segs.ax);
			uy_s1  <= (W+1)'(segs.by) - (W+1)'(segs.ay);
			vcx_s1 <= (W+1)'(segs.cx) - (W+1)'(segs.ax);
			vcy_s1 <= (W+1)'(segs.cy) - (W+1)'(segs.ay);
			vdx_s1 <= (W+1)'(segs.dx) - (W+1)'(segs.ax);
			vdy_s1 <= (W+1)'(segs.dy) - (W+1)'(segs.ay);
			ex_s1  <= (W+1)'(segs.dx) - (W+1)'(segs.cx);
			ey_s1  <= (W+1)'(segs.dy) - (W+1)'(segs.cy);
			wx_s1  <= (W+1)'(segs.bx) - (W+1)'(segs.cx);
			wy_s1  <= (W+1)'(segs.by) - (W+1)'(segs.cy);
			degen_s1 <= (segs.ax == segs.bx && segs.ay == segs.by) ||
				(segs.cx == segs.dx && segs.cy == segs.dy);
			shared_s1 <= (segs.ax == segs.cx && segs.ay == segs.cy) ||
				(segs.bx == segs.cx && segs.by == segs.cy) ||
				(segs.ax == segs.dx && segs.ay == segs.dy) ||
				(segs.bx == segs.dx && segs.by == segs.dy);
		end
	end

	// Stages 2-3: four cross products.
	// crc, crd: side of C and D relative to line AB.
	// fa, fb: side of A and B relative to line CD; the crossing point lies
	// on AB (ends inclusive) exactly when A and B are not strictly on the
	// same side of CD.
	logic signed [2*W+2:0] crc_s3, crd_s3, fa_s3, fb_s3;

	sit_cross #(.W(W)) u_crc (
		.clk(clk), .adv(adv),
		.a(ux_s1), .b(uy_s1), .c(vcx_s1), .d(vcy_s1), .res_s3(crc_s3)
	);
	sit_cross #(.W(W)) u_crd (
		.clk(clk), .adv(adv),
		.a(ux_s1), .b(uy_s1), .c(vdx_s1), .d(vdy_s1), .res_s3(crd_s3)
	);
	// (D-C) x (A-C) = ey*vcx - ex*vcy
	sit_cross #(.W(W)) u_fa (
		.clk(clk), .adv(adv),
		.a(ey_s1), .b(ex_s1), .c(vcy_s1), .d(vcx_s1), .res_s3(fa_s3)
	);
	// (D-C) x (B-C) = ex*wy - ey*wx
	sit_cross #(.W(W)) u_fb (
		.clk(clk), .adv(adv),
		.a(ex_s1), .b(ey_s1), .c(wx_s1), .d(wy_s1), .res_s3(fb_s3)
	);

	// Carry the early-out flags alongside the products
	logic degen_s2, shared_s2, degen_s3, shared_s3;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			degen_s2  <= degen_s1;
			shared_s2 <= shared_s1;
		end
		if (rdy3) begin
			degen_s3  <= degen_s2;
			shared_s3 <= shared_s2;
		end
	end

	// Stage 4: sign tests and verdict, in priority order
	logic crc_zero, crd_zero, fa_zero, fb_zero;
	sit_pkg::verdict_t verdict_d, verdict_s4;

	assign crc_zero = (crc_s3 == '0);
	assign crd_zero = (crd_s3 == '0);
	assign fa_zero  = (fa_s3 == '0);
	assign fb_zero  = (fb_s3 == '0);

	always_comb begin
		priority if (degen_s3) begin
			verdict_d = sit_pkg::V_DEGENERATE;
		end else if (shared_s3) begin
			verdict_d = sit_pkg::V_SHARED;
		end else if (crc_zero && crd_zero) begin
			verdict_d = sit_pkg::V_COLLINEAR;
		end else if (!crc_zero && !crd_zero &&
				(crc_s3[2*W+2] == crd_s3[2*W+2])) begin
			verdict_d = sit_pkg::V_SAME_SIDE;
		end else if (!fa_zero && !fb_zero && (fa_s3[2*W+2] == fb_s3[2*W+2])) begin
			verdict_d = sit_pkg::V_OUTSIDE;
		end else begin
			verdict_d = sit_pkg::V_CROSSING;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			verdict_s4 <= verdict_d;
		end
	end

	// Output word
	assign result.valid   = v_s4;
	assign result.verdict = verdict_s4;
	assign result.hit     = (verdict_s4 == sit_pkg::V_CROSSING) ||
		(verdict_s4 == sit_pkg::V_COLLINEAR);

endmodule

[hw/rtl/sit_checker.sv]
// Port-level checker for the segment intersection test, with its bind.
`include "segment_intersection_test_defines.svh"

module sit_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       hit,
	input logic [2:0] verdict
);

	// hit follows the verdict class
	`SIT_ASSERT_NOW(a_hit_class, clk, arst_n, out_valid, hit == ((verdict == sit_pkg::V_CROSSING) || (verdict == sit_pkg::V_COLLINEAR)))

	// an accepted word reaches the output while the receiver keeps ready high
	`SIT_ASSERT_NEXT(a_latency, clk, arst_n, (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready, out_valid)

	// a stalled result stays offered
	`SIT_ASSERT_NEXT(a_hold_valid, clk, arst_n, (out_valid && !out_ready), out_valid)

	// a stalled result keeps its value
	`SIT_ASSERT_NEXT(a_hold_word, clk, arst_n, (out_valid && !out_ready), $stable(verdict) && $stable(hit))

endmodule

bind segment_intersection_test sit_checker u_sit_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(segs.valid),
	.in_ready(segs.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.hit(result.hit),
	.verdict(result.verdict)
);

[tb/tb.sv]
// Self-checking testbench for the pipelined segment intersection test.
`timescale 1ns / 100ps

module tb;

	localparam int COORD_W = sit_pkg::COORD_WIDTH_DEF;
	localparam int HOLD_CYCLES = 60;       // long receiver hold-off, fills the pipeline
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
	localparam int RANDOM_PER_PHASE = 113;
	localparam int DRAIN_CYCLES = 8;       // four pipeline stages plus margin

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [127:0] wide_t;

	// One segment pair: endpoints A, B, C, D
	typedef struct {
		coord_t ax, ay, bx, by, cx, cy, dx, dy;
	} pair_t;

	// What one result word should carry
	typedef struct {
		logic              hit;
		sit_pkg::verdict_t verdict;
	} judgment_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sit_pt_if #(.W(COORD_W)) segs_ch ();
	sit_res_if res_ch ();

	segment_intersection_test #(.COORD_WIDTH(COORD_W)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.segs   (segs_ch),
		.result (res_ch)
	);

	always #5 clk = ~clk;

	pair_t     pending_pairs[$];      // filled by the stimulus, drained by the driver
	judgment_t expected_judgments[$]; // one per accepted pair, oldest first

	int   send_idle_pct = 0;    // chance per cycle that the sender offers nothing
	int   sink_stall_pct = 0;   // chance per cycle that the receiver drops ready
	logic hold_request = 1'b0;  // ask the receiver for one long hold-off
	logic hold_done = 1'b0;     // the long hold-off has been started
	int   stall_left = 0;
	logic seg_taken = 1'b0;     // the offered word was accepted at the last rising edge
	int   idle_cycles = 0;
	int   errors = 0;
	int   pairs_sent = 0;
	int   verdict_seen [6] = '{default: 0};

	// Build a pair from plain integers; keep only the low COORD_W bits.
	function automatic pair_t mk_pair(int ax, int ay, int bx, int by,
		int cx, int cy, int dx, int dy);
		pair_t p;
		p.ax = coord_t'(ax);
		p.ay = coord_t'(ay);
		p.bx = coord_t'(bx);
		p.by = coord_t'(by);
		p.cx = coord_t'(cx);
		p.cy = coord_t'(cy);
		p.dx = coord_t'(dx);
		p.dy = coord_t'(dy);
		return p;
	endfunction

	// Classify a pair with exact wide arithmetic: cross products give the side
	// of line AB, and the crossing position along AB is compared with both
	// ends without any division.
	function automatic sit_pkg::verdict_t classify_pair(pair_t p);
		wide_t ax_w, ay_w, bx_w, by_w, cx_w, cy_w, dx_w, dy_w;
		wide_t ux, uy, vcx, vcy, vdx, vdy;
		wide_t crc, crd, dotc, dotd, bb, num, den;
		if ((p.ax == p.bx && p.ay == p.by) || (p.cx == p.dx && p.cy == p.dy))
			return sit_pkg::V_DEGENERATE;
		if ((p.ax == p.cx && p.ay == p.cy) || (p.bx == p.cx && p.by == p.cy) ||
			(p.ax == p.dx && p.ay == p.dy) || (p.bx == p.dx && p.by == p.dy))
			return sit_pkg::V_SHARED;
		ax_w = p.ax;
		ay_w = p.ay;
		bx_w = p.bx;
		by_w = p.by;
		cx_w = p.cx;
		cy_w = p.cy;
		dx_w = p.dx;
		dy_w = p.dy;
		ux = bx_w - ax_w;
		uy = by_w - ay_w;
		vcx = cx_w - ax_w;
		vcy = cy_w - ay_w;
		vdx = dx_w - ax_w;
		vdy = dy_w - ay_w;
		crc = ux * vcy - uy * vcx;
		crd = ux * vdy - uy * vdx;
		if (crc == 0 && crd == 0)
			return sit_pkg::V_COLLINEAR;
		if (crc != 0 && crd != 0 && ((crc < 0) == (crd < 0)))
			return sit_pkg::V_SAME_SIDE;
		dotc = ux * vcx + uy * vcy;
		dotd = ux * vdx + uy * vdy;
		bb = ux * ux + uy * uy;
		// crossing position times |AB| is num / den, with den nonzero here
		num = dotc * crd - dotd * crc;
		den = crd - crc;
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		if (num < 0)
			return sit_pkg::V_OUTSIDE;
		if (bb * den - num < 0)
			return sit_pkg::V_OUTSIDE;
		return sit_pkg::V_CROSSING;
	endfunction

	function automatic int span_rand(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	// Random pair, weighted toward shapes that reach the deeper verdicts.
	function automatic pair_t random_pair();
		pair_t p;
		int    kind, px, py, ux, uy, vx, vy, a, b, c, d;
		kind = $urandom_range(99);
		if (kind < 35) begin
			// full range: every bit of every coordinate toggles
			p = mk_pair($urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
		end else if (kind < 60) begin
			// tiny grid: shared points, collinear and touching cases are common
			p = mk_pair(span_rand(3), span_rand(3), span_rand(3), span_rand(3),
				span_rand(3), span_rand(3), span_rand(3), span_rand(3));
		end else if (kind < 75) begin
			// all four points on one line through P
			px = span_rand(2000);
			py = span_rand(2000);
			ux = span_rand(3);
			uy = span_rand(3);
			a = span_rand(8);
			b = span_rand(8);
			c = span_rand(8);
			d = span_rand(8);
			p = mk_pair(px + a * ux, py + a * uy, px + b * ux, py + b * uy,
				px + c * ux, py + c * uy, px + d * ux, py + d * uy);
		end else if (kind < 90) begin
			// two segments through a common point P; zero steps put an
			// endpoint right on the other line
			px = span_rand(8000);
			py = span_rand(8000);
			ux = span_rand(2000);
			uy = span_rand(2000);
			vx = span_rand(2000);
			vy = span_rand(2000);
			a = $urandom_range(3);
			b = $urandom_range(3);
			c = $urandom_range(3);
			d = $urandom_range(3);
			p = mk_pair(px - a * ux, py - a * uy, px + b * ux, py + b * uy,
				px - c * vx, py - c * vy, px + d * vx, py + d * vy);
		end else begin
			// zero-length segments and shared endpoints on random content
			p = mk_pair($urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
			case ($urandom_range(3))
				0: begin
					p.bx = p.ax;
					p.by = p.ay;
				end
				1: begin
					p.dx = p.cx;
					p.dy = p.cy;
				end
				2: begin
					p.cx = $urandom_range(1) ? p.ax : p.bx;
					p.cy = (p.cx == p.ax) ? p.ay : p.by;
				end
				default: begin
					p.dx = $urandom_range(1) ? p.ax : p.bx;
					p.dy = (p.dx == p.ax) ? p.ay : p.by;
				end
			endcase
		end
		return p;
	endfunction

	// Wait until every queued pair has been taken and every result checked.
	task automatic drain();
		while (pending_pairs.size() != 0 || segs_ch.valid || expected_judgments.size() != 0)
			@(posedge clk);
	endtask

	// Driver: change inputs at the falling edge. Hold the offered word until
	// it is taken, then advance to the next pending pair or go idle.
	always @(negedge clk) begin : drive_pairs
		pair_t nxt;
		if (!arst_n) begin
			segs_ch.valid <= 1'b0;
			segs_ch.ax <= '0;
			segs_ch.ay <= '0;
			segs_ch.bx <= '0;
			segs_ch.by <= '0;
			segs_ch.cx <= '0;
			segs_ch.cy <= '0;
			segs_ch.dx <= '0;
			segs_ch.dy <= '0;
		end else if (segs_ch.valid && !seg_taken) begin
			// hold: the block has not taken the current word yet
		end else if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
			nxt = pending_pairs.pop_front();
			segs_ch.ax <= nxt.ax;
			segs_ch.ay <= nxt.ay;
			segs_ch.bx <= nxt.bx;
			segs_ch.by <= nxt.by;
			segs_ch.cx <= nxt.cx;
			segs_ch.cy <= nxt.cy;
			segs_ch.dx <= nxt.dx;
			segs_ch.dy <= nxt.dy;
			segs_ch.valid <= 1'b1;
		end else begin
			segs_ch.valid <= 1'b0;
		end
	end

	// Receiver: random stalls, plus one long hold-off counted here so the
	// pipeline fills and the block has to drop its input ready.
	always @(negedge clk) begin
		if (hold_request && !hold_done) begin
			stall_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			res_ch.ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Monitor: sample at the rising edge. Predict each accepted pair, check
	// each accepted result against the oldest prediction, and watch for hangs.
	always @(posedge clk) begin : watch_words
		pair_t             seen;
		judgment_t         want;
		sit_pkg::verdict_t v;
		seg_taken <= segs_ch.valid && segs_ch.ready;
		if (segs_ch.valid && segs_ch.ready) begin
			seen.ax = segs_ch.ax;
			seen.ay = segs_ch.ay;
			seen.bx = segs_ch.bx;
			seen.by = segs_ch.by;
			seen.cx = segs_ch.cx;
			seen.cy = segs_ch.cy;
			seen.dx = segs_ch.dx;
			seen.dy = segs_ch.dy;
			v = classify_pair(seen);
			want.verdict = v;
			want.hit = (v == sit_pkg::V_CROSSING || v == sit_pkg::V_COLLINEAR);
			expected_judgments.push_back(want);
			pairs_sent++;
		end
		if (res_ch.valid && res_ch.ready) begin
			if (expected_judgments.size() == 0) begin
				$display("%0t: result word with nothing expected: hit %0b verdict %0d",
					$time, res_ch.hit, res_ch.verdict);
				errors++;
			end else begin
				want = expected_judgments.pop_front();
				if (res_ch.hit !== want.hit) begin
					$display("%0t: hit mismatch: expected %0b, actual %0b",
						$time, want.hit, res_ch.hit);
					errors++;
				end
				if (res_ch.verdict !== want.verdict) begin
					$display("%0t: verdict mismatch: expected %0d (%s), actual %0d",
						$time, want.verdict, want.verdict.name(), res_ch.verdict);
					errors++;
				end
				verdict_seen[want.verdict]++;
			end
		end
		if ((segs_ch.valid && segs_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles, %0d results outstanding",
				$time, WATCHDOG_LIMIT, expected_judgments.size());
			$display("segment_intersection_test test failed");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, no idling on either side.
		// plain X crossing
		pending_pairs.push_back(mk_pair(0, 0, 16, 16, 0, 16, 16, 0));
		// full-scale diagonals, extremes of every field
		pending_pairs.push_back(mk_pair(-32768, -32768, 32767, 32767,
			-32768, 32767, 32767, -32768));
		pending_pairs.push_back(mk_pair(32767, 32767, -32768, -32768,
			32767, -32768, -32768, 32767));
		// zero-length AB, zero-length CD, both zero-length
		pending_pairs.push_back(mk_pair(5, 5, 5, 5, 0, 0, 10, 10));
		pending_pairs.push_back(mk_pair(0, 0, 10, 10, -3, 7, -3, 7));
		pending_pairs.push_back(mk_pair(-32768, 32767, -32768, 32767, 1, 1, 1, 1));
		// zero length together with a shared endpoint: degenerate wins
		pending_pairs.push_back(mk_pair(4, 4, 4, 4, 4, 4, 9, 0));
		// shared endpoint in each of the four pairings
		pending_pairs.push_back(mk_pair(0, 0, 16, 0, 0, 0, 8, 8));
		pending_pairs.push_back(mk_pair(0, 0, 16, 0, 16, 0, 8, 8));
		pending_pairs.push_back(mk_pair(0, 0, 16, 0, 8, 8, 0, 0));
		pending_pairs.push_back(mk_pair(0, 0, 16, 0, 8, -8, 16, 0));
		// both of CD strictly above AB
		pending_pairs.push_back(mk_pair(0, 0, 32, 0, 4, 4, 20, 9));
		// lines cross beyond B, and before A
		pending_pairs.push_back(mk_pair(0, 0, 16, 0, 40, -8, 40, 8));
		pending_pairs.push_back(mk_pair(0, 0, 16, 0, -1, -8, -1, 8));
		// collinear overlapping, collinear disjoint, collinear at full scale
		pending_pairs.push_back(mk_pair(0, 0, 32, 32, 16, 16, 48, 48));
		pending_pairs.push_back(mk_pair(0, 0, 8, 8, 16, 16, 24, 24));
		pending_pairs.push_back(mk_pair(-32768, 0, 32767, 0, -100, 0, 100, 0));
		// one endpoint of CD on line AB inside AB (T junction), other off
		pending_pairs.push_back(mk_pair(0, 0, 32, 0, 12, 0, 12, 20));
		// one endpoint on line AB beyond B
		pending_pairs.push_back(mk_pair(0, 0, 32, 0, 50, 0, 45, -20));
		// crossing exactly at B, and exactly at A: both ends inclusive
		pending_pairs.push_back(mk_pair(0, 0, 16, 0, 16, -16, 16, 16));
		pending_pairs.push_back(mk_pair(0, 0, 16, 0, 0, 16, 0, -16));
		// all-ones patterns
		pending_pairs.push_back(mk_pair(-1, -1, 1, 1, -1, 1, 1, -1));
		drain();

		// Random part in four idling phases; the first also carries the long
		// receiver hold-off while the sender keeps offering.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					sink_stall_pct = 0;
					hold_request = 1'b1;
				end
				1: begin
					send_idle_pct = 49;
					sink_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					sink_stall_pct = 49;
				end
				default: begin
					send_idle_pct = 20;
					sink_stall_pct = 20;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				pending_pairs.push_back(random_pair());
			drain();
		end

		// let the pipeline settle so a stray late word would still be seen
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d segment pairs across four idling phases and a long output stall.",
			pairs_sent);
		$display("Verdicts: crossing %0d, degenerate %0d, shared %0d,",
			verdict_seen[sit_pkg::V_CROSSING], verdict_seen[sit_pkg::V_DEGENERATE],
			verdict_seen[sit_pkg::V_SHARED]);
		$display("  same side %0d, outside %0d, collinear %0d",
			verdict_seen[sit_pkg::V_SAME_SIDE], verdict_seen[sit_pkg::V_OUTSIDE],
			verdict_seen[sit_pkg::V_COLLINEAR]);
		if (errors == 0 && expected_judgments.size() == 0) begin
			$display("segment_intersection_test test passed");
		end else begin
			$display("segment_intersection_test test failed");
		end
		$finish;
	end

endmodule
